@@ rtl/bts_pkg.sv @@
`default_nettype none

package bts_pkg;

    // fixed field widths
    localparam int COORD_W   = 17;
    localparam int COLOR_W   = 32;
    localparam int TXY_W     = 6;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;
    localparam int Q_FRAC    = 16;   // fraction bits of the Q1.16 coordinates
    localparam int CH_W      = 8;
    localparam int NUM_CH    = 4;

    // command codes
    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] SIZE_RESET = 7'd64;

endpackage

`default_nettype wire

@@ rtl/bts_fifo.sv @@
`default_nettype none

module bts_fifo #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4,
    localparam int PW   = $clog2(DEPTH),
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] rdata,
    output logic                  empty
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [PW-1:0]    wr_ptr_next, rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    assign wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

@@ rtl/bts_front.sv @@
`default_nettype none

module bts_front
    import bts_pkg::*;
#(
    parameter int MAX_WIDTH     = 64,
    parameter int MAX_HEIGHT    = 64,
    parameter int FRACTION_BITS = 8,
    localparam int XW = $clog2(MAX_WIDTH),
    localparam int YW = $clog2(MAX_HEIGHT),
    localparam int EW = 2 + 2 * XW + 2 * YW + 2 * FRACTION_BITS + COLOR_W
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 push,
    output logic                      full,
    input  wire logic                 command,
    input  wire logic [TXY_W-1:0]     texel_x,
    input  wire logic [TXY_W-1:0]     texel_y,
    input  wire logic [COLOR_W-1:0]   texel_color,
    input  wire logic [COORD_W-1:0]   coord_u,
    input  wire logic [COORD_W-1:0]   coord_v,
    output logic                      q_push,
    output logic      [EW-1:0]        q_data,
    input  wire logic                 q_full
);

    localparam int SWW  = $clog2(MAX_WIDTH + 1);
    localparam int SWH  = $clog2(MAX_HEIGHT + 1);
    localparam int CWW  = (SWW > CFG_W) ? SWW : CFG_W;
    localparam int CWH  = (SWH > CFG_W) ? SWH : CFG_W;
    localparam int PUW  = COORD_W + SWW;
    localparam int PVW  = COORD_W + SWH;

    typedef struct packed {
        logic                     cmd;
        logic                     wr_ok;
        logic [XW-1:0]            x0;
        logic [XW-1:0]            x1;
        logic [YW-1:0]            y0;
        logic [YW-1:0]            y1;
        logic [FRACTION_BITS-1:0] fu;
        logic [FRACTION_BITS-1:0] fv;
        logic [COLOR_W-1:0]       color;
    } entry_t;

    logic [CFG_W-1:0]   width_reg, height_reg;
    logic [CWW-1:0]     wext;
    logic [CWH-1:0]     hext;
    logic [SWW-1:0]     wm1;
    logic [SWH-1:0]     hm1;

    logic               s1_vld_reg, s1_vld_next;
    logic               s1_cmd_reg, s1_ok_reg;
    logic [XW-1:0]      s1_x_reg;
    logic [YW-1:0]      s1_y_reg;
    logic [COLOR_W-1:0] s1_color_reg;
    logic [PUW-1:0]     s1_pu_reg;
    logic [PVW-1:0]     s1_pv_reg;

    logic               in_acc, s1_adv, wr_ok;
    logic [SWW+1:0]     ipu, ipu1, limu, x0c, x1c;
    logic [SWH+1:0]     ipv, ipv1, limv, y0c, y1c;
    entry_t             ent;

    // ---- configuration ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SIZE_RESET;
            height_reg <= SIZE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_WIDTH:  width_reg  <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data;
            endcase
        end
    end

    // size in use minus one: zero counts as one, saturate at the maximum
    always_comb
    begin
        wext = CWW'(width_reg);
        hext = CWH'(height_reg);
        if (wext == '0)
            wm1 = '0;
        else if (wext > CWW'(MAX_WIDTH))
            wm1 = SWW'(MAX_WIDTH - 1);
        else
            wm1 = SWW'(wext - 1'b1);
        if (hext == '0)
            hm1 = '0;
        else if (hext > CWH'(MAX_HEIGHT))
            hm1 = SWH'(MAX_HEIGHT - 1);
        else
            hm1 = SWH'(hext - 1'b1);
    end

    // ---- stage 1: scale coordinates ----
    assign s1_adv = !s1_vld_reg || !q_full;
    assign full   = !s1_adv;
    assign in_acc = push && s1_adv;
    assign q_push = s1_vld_reg && !q_full;
    assign wr_ok  = (32'(texel_x) < 32'(MAX_WIDTH)) && (32'(texel_y) < 32'(MAX_HEIGHT));

    assign s1_vld_next = in_acc ? 1'b1 : (q_push ? 1'b0 : s1_vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else
            s1_vld_reg <= s1_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_cmd_reg   <= command;
            s1_ok_reg    <= wr_ok;
            s1_x_reg     <= XW'(texel_x);
            s1_y_reg     <= YW'(texel_y);
            s1_color_reg <= texel_color;
            s1_pu_reg    <= PUW'(coord_u) * PUW'(wm1);
            s1_pv_reg    <= PVW'(coord_v) * PVW'(hm1);
        end
    end

    // ---- stage 2: split into clamped indices and fraction (writes keep texel x/y) ----
    always_comb
    begin
        limu = (SWW + 2)'(wm1);
        limv = (SWH + 2)'(hm1);
        ipu  = (SWW + 2)'(s1_pu_reg[PUW-1:Q_FRAC]);
        ipv  = (SWH + 2)'(s1_pv_reg[PVW-1:Q_FRAC]);
        ipu1 = ipu + 1'b1;
        ipv1 = ipv + 1'b1;
        x0c  = (ipu  > limu) ? limu : ipu;
        x1c  = (ipu1 > limu) ? limu : ipu1;
        y0c  = (ipv  > limv) ? limv : ipv;
        y1c  = (ipv1 > limv) ? limv : ipv1;

        ent.cmd   = s1_cmd_reg;
        ent.wr_ok = s1_ok_reg;
        ent.x0    = (s1_cmd_reg == CMD_WRITE) ? s1_x_reg : XW'(x0c);
        ent.x1    = XW'(x1c);
        ent.y0    = (s1_cmd_reg == CMD_WRITE) ? s1_y_reg : YW'(y0c);
        ent.y1    = YW'(y1c);
        ent.fu    = s1_pu_reg[Q_FRAC-FRACTION_BITS +: FRACTION_BITS];
        ent.fv    = s1_pv_reg[Q_FRAC-FRACTION_BITS +: FRACTION_BITS];
        ent.color = s1_color_reg;
    end

    assign q_data = ent;

endmodule

`default_nettype wire

@@ rtl/bts_back.sv @@
`default_nettype none

module bts_back
    import bts_pkg::*;
#(
    parameter int MAX_WIDTH     = 64,
    parameter int MAX_HEIGHT    = 64,
    parameter int FRACTION_BITS = 8,
    localparam int XW = $clog2(MAX_WIDTH),
    localparam int YW = $clog2(MAX_HEIGHT),
    localparam int EW = 2 + 2 * XW + 2 * YW + 2 * FRACTION_BITS + COLOR_W
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_empty,
    input  wire logic [EW-1:0]      q_data,
    output logic                    q_pop,
    output logic                    empty,
    input  wire logic               pop,
    output logic      [COLOR_W-1:0] sample_color
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int PRW   = FRACTION_BITS + 10;

    typedef struct packed {
        logic                     cmd;
        logic                     wr_ok;
        logic [XW-1:0]            x0;
        logic [XW-1:0]            x1;
        logic [YW-1:0]            y0;
        logic [YW-1:0]            y1;
        logic [FRACTION_BITS-1:0] fu;
        logic [FRACTION_BITS-1:0] fv;
        logic [COLOR_W-1:0]       color;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_HBLEND,
        ST_OUT
    } state_t;

    state_t             state_reg;
    logic [1:0]         idx_reg, cap_idx_reg;
    logic               cap_vld_reg, res_vld_reg;
    entry_t             ent, cur_reg;
    logic               mem_we, load_res;
    logic [AW-1:0]      wr_addr, rd_addr;
    logic [XW-1:0]      rx;
    logic [YW-1:0]      ry;

    logic [COLOR_W-1:0] texel_mem [DEPTH];
    logic [COLOR_W-1:0] rd_data_reg;
    logic [COLOR_W-1:0] tex_reg [NUM_CH];
    logic [CH_W-1:0]    top_reg [NUM_CH];
    logic [CH_W-1:0]    bot_reg [NUM_CH];
    logic [COLOR_W-1:0] res_reg;

    // a + (b - a) * f / 2^F, quotient truncated toward zero
    function automatic logic [CH_W-1:0] blend(input logic [CH_W-1:0] a,
                                              input logic [CH_W-1:0] b,
                                              input logic [FRACTION_BITS-1:0] f);
        logic signed [CH_W:0]  d;
        logic signed [PRW-1:0] prod;
        logic signed [PRW-1:0] mag;
        logic signed [PRW-1:0] q;
        logic signed [PRW-1:0] sum;
        d    = $signed({1'b0, b}) - $signed({1'b0, a});
        prod = d * $signed({1'b0, f});
        mag  = prod[PRW-1] ? -prod : prod;
        q    = mag >>> FRACTION_BITS;
        if (prod[PRW-1])
            q = -q;
        sum  = $signed({{(PRW-CH_W){1'b0}}, a}) + q;
        return sum[CH_W-1:0];
    endfunction

    assign ent      = q_data;
    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;
    assign mem_we   = q_pop && (ent.cmd == CMD_WRITE) && ent.wr_ok;
    assign load_res = (state_reg == ST_OUT) && (!res_vld_reg || pop);
    assign empty    = !res_vld_reg;
    assign sample_color = res_reg;

    // corner order: 0 = (x0,y0), 1 = (x1,y0), 2 = (x0,y1), 3 = (x1,y1)
    assign rx      = idx_reg[0] ? cur_reg.x1 : cur_reg.x0;
    assign ry      = idx_reg[1] ? cur_reg.y1 : cur_reg.y0;
    assign rd_addr = AW'(ry) * AW'(MAX_WIDTH) + AW'(rx);
    assign wr_addr = AW'(ent.y0) * AW'(MAX_WIDTH) + AW'(ent.x0);

    // texel store, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            texel_mem[wr_addr] <= ent.color;
        end
        rd_data_reg <= texel_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            cap_idx_reg <= '0;
            cap_vld_reg <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            cap_vld_reg <= (state_reg == ST_READ);
            cap_idx_reg <= idx_reg;
            if (load_res)
                res_vld_reg <= 1'b1;
            else if (pop)
                res_vld_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    idx_reg <= '0;
                    if (q_pop && (ent.cmd == CMD_SAMPLE))
                        state_reg <= ST_READ;
                end
                ST_READ:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == 2'd3)
                        state_reg <= ST_DRAIN;
                end
                ST_DRAIN:  state_reg <= ST_HBLEND;
                ST_HBLEND: state_reg <= ST_OUT;
                ST_OUT:
                begin
                    if (load_res)
                        state_reg <= ST_IDLE;
                end
                default:   state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= ent;
        end
        if (cap_vld_reg)
        begin
            tex_reg[cap_idx_reg] <= rd_data_reg;
        end
        if (state_reg == ST_HBLEND)
        begin
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                top_reg[ch] <= blend(tex_reg[0][ch*CH_W +: CH_W],
                                     tex_reg[1][ch*CH_W +: CH_W], cur_reg.fu);
                bot_reg[ch] <= blend(tex_reg[2][ch*CH_W +: CH_W],
                                     tex_reg[3][ch*CH_W +: CH_W], cur_reg.fu);
            end
        end
        if (load_res)
        begin
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                res_reg[ch*CH_W +: CH_W] <= blend(top_reg[ch], bot_reg[ch], cur_reg.fv);
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/bilinear_texture_sampler.sv @@
// Bilinear texture sampler, clamp to edge, RGBA8888 texels.
// Input channel: push/full. command = write stores texel_color at
// (texel_x, texel_y); command = sample filters at (coord_u, coord_v), Q1.16.
// Result channel: empty/pop. One sample_color beat per sample, none per write.
// Config: cfg_write/cfg_index/cfg_data set width and height in use; write only
// while the block is idle.
// Front end scales coordinates (one register stage) and splits them into
// clamped corner indices and fractions on the way into a 4-entry command queue.
// Back end: a write is stored as it is popped; a sample steps through its pop,
// the four corner reads through the single read port of the texel store, then
// one drain, one horizontal blend and one vertical blend step.
// The front keeps accepting beats while the back works, until the queue fills.
// A stalled result (pop low) holds the back end in its last step; the front
// and queue go on taking beats until full.
// Reset clears queue, pipeline and result; sizes go to 64. The texel store is
// not cleared: a texel must be written before it is sampled.
`default_nettype none

module bilinear_texture_sampler
    import bts_pkg::*;
#(
    parameter int MAX_WIDTH     = 64,
    parameter int MAX_HEIGHT    = 64,
    parameter int FRACTION_BITS = 8
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 push,
    output logic                      full,
    input  wire logic                 command,
    input  wire logic [TXY_W-1:0]     texel_x,
    input  wire logic [TXY_W-1:0]     texel_y,
    input  wire logic [COLOR_W-1:0]   texel_color,
    input  wire logic [COORD_W-1:0]   coord_u,
    input  wire logic [COORD_W-1:0]   coord_v,
    output logic                      empty,
    input  wire logic                 pop,
    output logic      [COLOR_W-1:0]   sample_color
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int YW = $clog2(MAX_HEIGHT);
    localparam int EW = 2 + 2 * XW + 2 * YW + 2 * FRACTION_BITS + COLOR_W;

    // front -> queue -> back
    logic          q_push, q_full, q_pop, q_empty;
    logic [EW-1:0] q_wdata, q_rdata;

    bts_front #(
        .MAX_WIDTH     (MAX_WIDTH),
        .MAX_HEIGHT    (MAX_HEIGHT),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .push        (push),
        .full        (full),
        .command     (command),
        .texel_x     (texel_x),
        .texel_y     (texel_y),
        .texel_color (texel_color),
        .coord_u     (coord_u),
        .coord_v     (coord_v),
        .q_push      (q_push),
        .q_data      (q_wdata),
        .q_full      (q_full)
    );

    // command queue decouples the front from the store/blend back end
    bts_fifo #(
        .WIDTH (EW),
        .DEPTH (4)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    bts_back #(
        .MAX_WIDTH     (MAX_WIDTH),
        .MAX_HEIGHT    (MAX_HEIGHT),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_data       (q_rdata),
        .q_pop        (q_pop),
        .empty        (empty),
        .pop          (pop),
        .sample_color (sample_color)
    );

`ifndef NO_ASSERTIONS
    // front never pushes into a full queue
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("front pushed into full command queue");

    // back never pops an empty queue
    a_pop_avail: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("back popped empty command queue");

    // input stalls only while the queue is full
    a_full_cause: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> q_full)
        else $error("input stalled with room in the queue");
`endif

endmodule

`default_nettype wire
